>>> rtl/aprt_pkg.sv
// Package for the adaptive probabilistic rate throttle: field widths, defaults
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package aprt_pkg;

	// Field widths fixed by the stream format.
	localparam int TIME_W = 32;
	localparam int RND_W = 16;
	localparam int RATE_W = 16;
	localparam int CNT_W = 32;

	// 1000 * count needs 42 bits, max_rate * elapsed needs 48 bits.
	localparam int MS_PER_SEC = 1000;
	localparam int EVENTS_W = 42;
	localparam int ALLOWED_W = 48;
	// Partial remainder before reduction stays below three divisors.
	localparam int REM_W = EVENTS_W + 2;

	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 8;

	localparam int EVAL_INTERVAL_MS_DEF = 100;
	localparam int RANDOM_BITS_DEF = 16;
	localparam logic [RATE_W-1:0] MAX_RATE_RESET = RATE_W'(50);

	typedef struct packed {
		logic accept;    // capture the item, bump the sample count
		logic mul;       // form events and allowed products
		logic cmp;       // rate test, zero threshold or start the divider
		logic div_step;  // one quotient bit
		logic update;    // restart the window
		logic load_out;  // register the pass decision
	} aprt_cmd_t;

	typedef struct packed {
		logic trigger;   // arrival time is past the next evaluation time
		logic below;     // measured rate is below max_rate
		logic div_last;  // current divider step is the final one
		logic out_full;  // output register holds an item not taken this cycle
	} aprt_sts_t;

endpackage

>>> rtl/aprt_ctrl.sv
// Controller state machine of the rate throttle.
// Depends on aprt_pkg for the command and status structs.
`timescale 1ns / 1ps

module aprt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aprt_pkg::aprt_sts_t sts,
	output aprt_pkg::aprt_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= sts.trigger ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= sts.below ? ST_UPDATE : ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!sts.out_full) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.cmp      = (state_q == ST_CMP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.load_out = (state_q == ST_DONE) && !sts.out_full;
	end

endmodule

>>> rtl/aprt_datapath.sv
// Datapath of the rate throttle: window state, products, radix-2 divider
// and the output register. Depends on aprt_pkg.
`timescale 1ns / 1ps

module aprt_datapath #(
	parameter int EVAL_INTERVAL_MS = aprt_pkg::EVAL_INTERVAL_MS_DEF,
	parameter int RANDOM_BITS = aprt_pkg::RANDOM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aprt_pkg::aprt_cmd_t           cmd,
	output aprt_pkg::aprt_sts_t           sts,
	input  logic [aprt_pkg::TIME_W-1:0]   now_ms,
	input  logic [aprt_pkg::RND_W-1:0]    random_value,
	input  logic                          cfg_we,
	input  logic [aprt_pkg::RATE_W-1:0]   cfg_max_rate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pass
);

	localparam int TW = aprt_pkg::TIME_W;
	localparam int RW = aprt_pkg::REM_W;
	localparam int STEP_W = $clog2(RANDOM_BITS);
	localparam int CMP_W = (RANDOM_BITS > aprt_pkg::RND_W) ? RANDOM_BITS : aprt_pkg::RND_W;
	localparam logic [RANDOM_BITS-1:0] RMAX = {RANDOM_BITS{1'b1}};
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RANDOM_BITS - 1);
	localparam logic [aprt_pkg::CNT_W-1:0] CNT_MAX = {aprt_pkg::CNT_W{1'b1}};

	// Architectural state.
	logic [aprt_pkg::RATE_W-1:0] max_rate_q;
	logic [TW-1:0]               window_start_q;
	logic [TW-1:0]               next_eval_q;
	logic [aprt_pkg::CNT_W-1:0]  count_q;
	logic [RANDOM_BITS-1:0]      thr_q;

	// Per-item working registers.
	logic [TW-1:0]                  now_q;
	logic [aprt_pkg::RND_W-1:0]     rnd_q;
	logic                           trigger_q;
	logic [TW-1:0]                  elapsed_q;
	logic [aprt_pkg::EVENTS_W-1:0]  events_q;
	logic [aprt_pkg::ALLOWED_W-1:0] allowed_q;
	logic [RW-1:0]                  rem_q;
	logic [RANDOM_BITS-1:0]         quo_q;
	logic [STEP_W-1:0]              step_q;
	logic                           out_valid_q;
	logic                           pass_q;

	// Divider step: the numerator adds allowed at every bit since RMAX is all
	// ones, so the partial remainder stays below three divisors.
	logic [RW-1:0]          div_d;
	logic [RW-1:0]          div_d2;
	logic [RW-1:0]          div_t;
	logic [RW-1:0]          rem_next;
	logic [1:0]             digit;
	logic [RANDOM_BITS-1:0] quo_next;

	always_comb begin
		div_d  = RW'(events_q);
		div_d2 = {div_d[RW-2:0], 1'b0};
		div_t  = {rem_q[RW-2:0], 1'b0} + RW'(allowed_q);
		if (div_t >= div_d2) begin
			rem_next = div_t - div_d2;
			digit    = 2'd2;
		end else if (div_t >= div_d) begin
			rem_next = div_t - div_d;
			digit    = 2'd1;
		end else begin
			rem_next = div_t;
			digit    = 2'd0;
		end
		quo_next = (quo_q << 1) + RANDOM_BITS'(digit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q     <= aprt_pkg::MAX_RATE_RESET;
			window_start_q <= '0;
			next_eval_q    <= '0;
			count_q        <= '0;
			thr_q          <= '0;
			trigger_q      <= 1'b0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) max_rate_q <= cfg_max_rate;

			if (cmd.accept) begin
				if (count_q != CNT_MAX) count_q <= count_q + 1'b1;
				trigger_q <= (now_ms > next_eval_q);
			end

			if (cmd.cmp) begin
				step_q <= '0;
				if (sts.below) thr_q <= '0;
			end

			if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) thr_q <= RMAX - quo_next;
			end

			if (cmd.update) begin
				window_start_q <= now_q;
				next_eval_q    <= now_q + TW'(EVAL_INTERVAL_MS);
				count_q        <= '0;
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q     <= now_ms;
			rnd_q     <= random_value;
			elapsed_q <= now_ms - window_start_q;
		end
		if (cmd.mul) begin
			events_q  <= aprt_pkg::EVENTS_W'(count_q) *
			             aprt_pkg::EVENTS_W'(aprt_pkg::MS_PER_SEC);
			allowed_q <= aprt_pkg::ALLOWED_W'(max_rate_q) *
			             aprt_pkg::ALLOWED_W'(elapsed_q);
		end
		if (cmd.cmp) begin
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (cmd.load_out) begin
			pass_q <= (CMP_W'(rnd_q) > CMP_W'(thr_q));
		end
	end

	always_comb begin
		sts.trigger  = trigger_q;
		sts.below    = (aprt_pkg::ALLOWED_W'(events_q) < allowed_q);
		sts.div_last = (step_q == LAST_STEP);
		sts.out_full = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign pass      = pass_q;

endmodule

>>> rtl/adaptive_probabilistic_rate_throttle_top.sv
// Top level of the adaptive probabilistic rate throttle.
// Depends on aprt_pkg, aprt_ctrl and aprt_datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake                  Payload
//  s_axis   in         s_axis_tvalid/tready       tdata: now_ms, random_value
//  m_axis   out        m_axis_tvalid/tready       tdata: pass
//  cfg      in         cfg_valid/cfg_ready        cfg_data: max_rate
//
// An item that does not start an evaluation passes from acceptance through the
// check and done states back to idle. An item whose arrival time is past the
// next evaluation time also passes through the multiply, compare and update
// states and, when the measured rate is not below max_rate, through the divide
// state, where the radix-2 divider produces one quotient bit per cycle. Reset
// is asynchronous and active low; it restores max_rate to 50 and clears the
// window, the count and the threshold. The output register decouples the two
// sides: a new item is taken while a result is still waiting, and only the
// final step that writes the output register waits for m_axis_tready.

module adaptive_probabilistic_rate_throttle_top #(
	parameter int EVAL_INTERVAL_MS = aprt_pkg::EVAL_INTERVAL_MS_DEF,
	parameter int RANDOM_BITS = aprt_pkg::RANDOM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0: now_ms [31:0], random_value [47:32].
	input  logic [aprt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: pass [0], zero fill [7:1].
	output logic [aprt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aprt_pkg::RATE_W-1:0]       cfg_data
);

	aprt_pkg::aprt_cmd_t cmd;
	aprt_pkg::aprt_sts_t sts;
	logic                pass;

	// The register write is always taken, also while an item is in progress.
	assign cfg_ready = 1'b1;

	aprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aprt_datapath #(
		.EVAL_INTERVAL_MS (EVAL_INTERVAL_MS),
		.RANDOM_BITS      (RANDOM_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.now_ms       (s_axis_tdata[aprt_pkg::TIME_W-1:0]),
		.random_value (s_axis_tdata[aprt_pkg::TIME_W +: aprt_pkg::RND_W]),
		.cfg_we       (cfg_valid),
		.cfg_max_rate (cfg_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pass         (pass)
	);

	// The pass decision sits in bit 0; the rest of the byte is zero.
	assign m_axis_tdata = aprt_pkg::OUT_DATA_W'(pass);

endmodule

>>> tb/throttle_checker.sv
// Checker for the adaptive probabilistic rate throttle: follows the sample,
// result and rate channels, predicts each pass decision and compares it.
// Depends on aprt_pkg.
`timescale 1ns / 1ps

module throttle_checker #(
	parameter int EVAL_INTERVAL_MS = aprt_pkg::EVAL_INTERVAL_MS_DEF,
	parameter int RANDOM_BITS = aprt_pkg::RANDOM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [aprt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [aprt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [aprt_pkg::RATE_W-1:0]       cfg_data,
	output int                                mismatches,
	output int                                outstanding
);

	localparam logic [63:0] RND_MAX = (64'd1 << RANDOM_BITS) - 64'd1;

	logic [aprt_pkg::RATE_W-1:0] rate_limit;
	logic [aprt_pkg::TIME_W-1:0] window_ms;
	logic [aprt_pkg::TIME_W-1:0] eval_due_ms;
	logic [aprt_pkg::CNT_W-1:0]  samples_seen;
	logic [RANDOM_BITS-1:0]      discard_thr;
	logic                        pass_due[$];
	int                          err_count;

	assign mismatches = err_count;

	// Threshold after an evaluation: zero when the measured rate is below the
	// limit, otherwise the share of the random range that must be discarded.
	function automatic logic [RANDOM_BITS-1:0] discard_level(
		input logic [aprt_pkg::CNT_W-1:0]  count,
		input logic [aprt_pkg::TIME_W-1:0] elapsed,
		input logic [aprt_pkg::RATE_W-1:0] rate
	);
		logic [63:0]  events;
		logic [63:0]  allowed;
		logic [127:0] keep_share;
		events = 64'(count) * 64'(aprt_pkg::MS_PER_SEC);
		allowed = 64'(rate) * 64'(elapsed);
		if (events < allowed)
			return '0;
		keep_share = 128'(RND_MAX) * 128'(allowed) / 128'(events);
		return RANDOM_BITS'(RND_MAX - keep_share[63:0]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [aprt_pkg::TIME_W-1:0] now_ms;
		logic [aprt_pkg::RND_W-1:0]  rnd;
		logic                        want;
		if (!arst_n) begin
			rate_limit = aprt_pkg::MAX_RATE_RESET;
			window_ms = '0;
			eval_due_ms = '0;
			samples_seen = '0;
			discard_thr = '0;
			pass_due.delete();
			err_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				rate_limit = cfg_data;

			// Results are matched before new items are queued, so a result can
			// never be credited to an item accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (pass_due.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual pass %0b",
						$time, m_axis_tdata[0]);
					err_count++;
				end else begin
					want = pass_due.pop_front();
					if (m_axis_tdata[0] !== want) begin
						$display("%0t: pass mismatch, expected %0b, actual %0b",
							$time, want, m_axis_tdata[0]);
						err_count++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				now_ms = s_axis_tdata[31:0];
				rnd = s_axis_tdata[47:32];
				if (samples_seen != '1)
					samples_seen = samples_seen + 1'b1;
				if (now_ms > eval_due_ms) begin
					discard_thr = discard_level(samples_seen, now_ms - window_ms, rate_limit);
					window_ms = now_ms;
					samples_seen = '0;
					eval_due_ms = now_ms + aprt_pkg::TIME_W'(EVAL_INTERVAL_MS);
				end
				pass_due.push_back(rnd > discard_thr);
			end

			outstanding <= pass_due.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Testbench top for the adaptive probabilistic rate throttle: drives samples,
// rate writes and result back-pressure, and gives the verdict.
// Depends on aprt_pkg, adaptive_probabilistic_rate_throttle_top and throttle_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam int EVAL_MS = 100;
	localparam int RND_BITS = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [31:0] TOP_MS = 32'hFFFF_FFFF;
	localparam logic [15:0] RND_TOP = 16'hFFFF;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	// Fields from bit 0: now_ms [31:0], random_value [47:32].
	logic [aprt_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	// Fields from bit 0: pass [0], zero fill [7:1].
	logic [aprt_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [aprt_pkg::RATE_W-1:0]       cfg_data = '0;

	int          errors;
	int          pending;
	int          idle_cycles = 0;
	int          samples_sent = 0;
	bit          steady = 1'b0;       // when set, neither side idles
	logic [31:0] clock_ms = '0;       // running arrival time of the random phases

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	adaptive_probabilistic_rate_throttle_top #(
		.EVAL_INTERVAL_MS(EVAL_MS),
		.RANDOM_BITS(RND_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	throttle_checker #(
		.EVAL_INTERVAL_MS(EVAL_MS),
		.RANDOM_BITS(RND_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(errors),
		.outstanding(pending)
	);

	// Offers one sample after a random gap, none while steady is set, and holds it until it is taken.
	// Valid stays high afterwards so back-to-back items need not drop it in between.
	task automatic send_sample(input logic [31:0] now_ms, input logic [15:0] rnd);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rnd, now_ms};
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	// Stops offering samples and waits until every pass decision has come back.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// The rate limit is only changed while the throttle holds no work.
	task automatic set_max_rate(input logic [15:0] rate);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= rate;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly a well-behaved clock moving forward at the phase's pace, with
	// quiet spells, late stamps, arbitrary jumps and stamps just below the wrap.
	task automatic random_phase(input int items);
		int          step_hi;
		int          pick;
		logic [15:0] rnd;
		case ($urandom_range(0, 4))
			0: step_hi = 1;
			1: step_hi = 8;
			2: step_hi = 25;
			3: step_hi = 60;
			default: step_hi = 200;
		endcase
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				clock_ms = clock_ms + $urandom_range(0, step_hi);
			else if (pick < 88)
				clock_ms = clock_ms + $urandom_range(100, 400);
			else if (pick < 93)
				clock_ms = clock_ms - $urandom_range(0, 300);
			else if (pick < 97)
				clock_ms = $urandom();
			else
				clock_ms = TOP_MS - $urandom_range(0, 150);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				rnd = '0;
			else if (pick < 16)
				rnd = RND_TOP;
			else
				rnd = 16'($urandom_range(0, 65535));
			send_sample(clock_ms, rnd);
		end
	endtask

	function automatic logic [15:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return RND_TOP;
			2: return 16'd1;
			3: return 16'($urandom_range(2, 100));
			4: return 16'($urandom_range(100, 2000));
			default: return 16'($urandom());
		endcase
	endfunction

	// Result side: a fresh stall for every result, none while steady is set.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog: any accepted item on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles < IDLE_LIMIT) begin
			idle_cycles <= idle_cycles + 1;
		end else begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default limit of 50 per second: a sample at time zero does not
		// evaluate, the next one does with a one-millisecond window.
		send_sample(32'd0, 16'd0);
		send_sample(32'd1, RND_TOP);
		send_sample(32'd50, 16'h8000);
		send_sample(32'd60, 16'd1);
		send_sample(32'd102, 16'h1234);
		// Latest possible stamp: the next evaluation time wraps past zero, so
		// the same stamp evaluates again with no elapsed time.
		send_sample(TOP_MS, 16'd0);
		send_sample(TOP_MS, RND_TOP);
		send_sample(TOP_MS, 16'hFFFE);
		send_sample(32'd16, 16'd5);
		send_sample(32'd200, 16'h7FFF);

		// A zero limit can never be met, so every evaluation discards all.
		set_max_rate(16'd0);
		send_sample(32'd300, RND_TOP);
		send_sample(32'd450, RND_TOP);
		send_sample(32'd460, 16'h0001);

		// Highest limit: the measured rate is always below it.
		set_max_rate(16'hFFFF);
		send_sample(32'd470, 16'd0);
		send_sample(32'd600, 16'd1);
		send_sample(32'd601, 16'd0);

		// A burst under a moderate limit, averaged over its window, stays below it and gives a zero threshold.
		set_max_rate(16'd100);
		for (int i = 0; i < 8; i++)
			send_sample(32'd610 + 32'(i * 5), 16'($urandom()));
		send_sample(32'd760, 16'hC000);

		clock_ms = 32'd760;
		while (samples_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			set_max_rate(pick_rate());
			random_phase($urandom_range(100, 250));
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
